/* sv/dca_pkg.sv */
// ----------------------------------------------------------------------------
// dca_pkg: shared types and constants for the key dedup cache
// Item structs, controller/datapath command and status groups, status codes.
// ----------------------------------------------------------------------------
package dca_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int KEY_BYTES   = 8;
	localparam int KEY_W       = 64;
	localparam int LEN_W       = 8;
	localparam int SLEN_W      = 4;
	localparam int CNT_W       = 8;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);
	localparam int INS_W       = 7;
	localparam int MAXLEN_W    = 4;
	localparam int THR_W       = 6;
	localparam int CFG_DATA_W  = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int STATUS_W    = 3;
	localparam int SLOT_W      = 6;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_KEY_LEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AGE_THR     = 1'd1;

	localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 4'd8;
	localparam logic [THR_W-1:0]    THR_RST    = 6'd25;
	localparam logic [CNT_W-1:0]    CNT_MAX    = 8'hFF;
	localparam logic [INS_W-1:0]    INS_MAX    = 7'd127;

	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0] key_bytes;
		logic [LEN_W-1:0] key_length;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_index;
		logic                aging_done;
	} out_item_t;

	typedef struct packed {
		logic [SLEN_W-1:0] len;
		logic [KEY_W-1:0]  key;
	} ent_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic age;
		logic decide;
		logic age_end;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic bypass;
		logic idx_last;
		logic need_age;
		logic out_free;
	} sts_t;

endpackage

/* sv/dca_ctrl.sv */
// ----------------------------------------------------------------------------
// dca_ctrl: sequencer for the key dedup cache
// Steps one item through capture, table scan, decision, aging when needed and output;
// empty or too-long keys skip from capture straight to output.
module dca_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dca_pkg::sts_t sts,
	output dca_pkg::cmd_t cmd
);
	import dca_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_CHECK    = 8'b0000_0010,
		S_SCAN     = 8'b0000_0100,
		S_SCAN_END = 8'b0000_1000,
		S_DECIDE   = 8'b0001_0000,
		S_AGE      = 8'b0010_0000,
		S_AGE_END  = 8'b0100_0000,
		S_FINISH   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = sts.bypass ? S_FINISH : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.idx_last) state_d = S_SCAN_END;
			end
			S_SCAN_END: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.need_age ? S_AGE : S_FINISH;
			end
			S_AGE: begin
				cmd.age = 1'b1;
				if (sts.idx_last) state_d = S_AGE_END;
			end
			S_AGE_END: begin
				cmd.age_end = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

/* sv/dca_datapath.sv */
// ----------------------------------------------------------------------------
// dca_datapath: table storage, scan compare, aging sweep and output register
// Key/length and hit counters live in memories; free bits are flops.
// ----------------------------------------------------------------------------
module dca_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dca_pkg::in_item_t                  in_item,
	input  logic                               cfg_we,
	input  logic [dca_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dca_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output dca_pkg::out_item_t                 out_item,
	input  dca_pkg::cmd_t                      cmd,
	output dca_pkg::sts_t                      sts
);
	import dca_pkg::*;

	ent_t             ent_mem [NUM_ENTRIES];
	logic [CNT_W-1:0] cnt_mem [NUM_ENTRIES];

	logic [NUM_ENTRIES-1:0] free_q;
	logic [MAXLEN_W-1:0]    max_len_q;
	logic [THR_W-1:0]       thr_q;
	logic [INS_W-1:0]       ins_cnt_q;

	logic [KEY_W-1:0]  key_q;
	logic [SLEN_W-1:0] len_q;
	logic              bypass_q;
	logic [ADDR_W-1:0] idx_q;

	logic              vld_s1, age_s1;
	logic [ADDR_W-1:0] addr_s1;
	ent_t              ent_s1;
	logic [CNT_W-1:0]  cnt_s1;

	logic              found_q, have_free_q;
	logic [ADDR_W-1:0] found_idx_q, free_idx_q;
	logic [CNT_W-1:0]  found_cnt_q;

	out_item_t res_q, out_q;
	logic      out_valid_q;

	logic [KEY_W-1:0]    key_m;
	logic [MAXLEN_W-1:0] limit;
	logic                is_empty, too_long;
	logic [INS_W-1:0]    ins_next;
	logic                ins_age;
	logic                do_hit, do_ins, age_wr, age_free;
	logic                cnt_we;
	logic [ADDR_W-1:0]   cnt_wa;
	logic [CNT_W-1:0]    cnt_wd;

	// bytes above the length do not take part in the match
	always_comb begin
		key_m = in_item.key_bytes;
		for (int b = 0; b < KEY_W / 8; b++) begin
			if (LEN_W'(b) >= in_item.key_length) key_m[b*8 +: 8] = 8'h00;
		end
	end

	assign limit    = (max_len_q < MAXLEN_W'(KEY_BYTES)) ? max_len_q : MAXLEN_W'(KEY_BYTES);
	assign is_empty = (in_item.key_length == '0);
	assign too_long = (in_item.key_length > LEN_W'(limit));

	assign ins_next = (ins_cnt_q < INS_MAX) ? ins_cnt_q + 1'b1 : ins_cnt_q;
	assign ins_age  = (ins_next > INS_W'(thr_q));

	assign do_hit   = cmd.decide && found_q;
	assign do_ins   = cmd.decide && !found_q && have_free_q;
	assign age_wr   = vld_s1 && age_s1 && !free_q[addr_s1];
	assign age_free = age_wr && (cnt_s1 == '0);

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = addr_s1;
		cnt_wd = cnt_s1 >> 1;
		if (do_hit) begin
			cnt_we = 1'b1;
			cnt_wa = found_idx_q;
			cnt_wd = (found_cnt_q == CNT_MAX) ? CNT_MAX : found_cnt_q + 1'b1;
		end else if (do_ins) begin
			cnt_we = 1'b1;
			cnt_wa = free_idx_q;
			cnt_wd = ins_age ? CNT_W'(1) : '0;
		end else if (age_wr && !age_free) begin
			cnt_we = 1'b1;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (do_ins) ent_mem[free_idx_q] <= '{len: len_q, key: key_q};
		if (cmd.scan) ent_s1 <= ent_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (cmd.scan || cmd.age) cnt_s1 <= cnt_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_m;
			len_q <= in_item.key_length[SLEN_W-1:0];
		end
		if (cmd.scan || cmd.age) addr_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAXLEN_RST;
			thr_q     <= THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_KEY_LEN: max_len_q <= cfg_data[MAXLEN_W-1:0];
				REG_AGE_THR:     thr_q     <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q      <= '1;
			ins_cnt_q   <= '0;
			bypass_q    <= 1'b0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			age_s1      <= 1'b0;
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
			found_idx_q <= '0;
			free_idx_q  <= '0;
			found_cnt_q <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan || cmd.age;
			age_s1 <= cmd.age;

			if (cmd.load || cmd.decide) idx_q <= '0;
			else if (cmd.scan || cmd.age) idx_q <= idx_q + 1'b1;

			if (cmd.load) begin
				bypass_q    <= is_empty || too_long;
				found_q     <= 1'b0;
				have_free_q <= 1'b0;
				res_q       <= '{status: is_empty ? ST_EMPTY : ST_TOO_LONG,
					slot_index: '0, aging_done: 1'b0};
			end

			// scan compare, first used match and lowest free slot
			if (vld_s1 && !age_s1) begin
				if (free_q[addr_s1]) begin
					if (!have_free_q) begin
						have_free_q <= 1'b1;
						free_idx_q  <= addr_s1;
					end
				end else if (!found_q && ent_s1.len == len_q && ent_s1.key == key_q) begin
					found_q     <= 1'b1;
					found_idx_q <= addr_s1;
					found_cnt_q <= cnt_s1;
				end
			end

			if (cmd.decide) begin
				if (found_q)
					res_q <= '{status: ST_HIT, slot_index: SLOT_W'(found_idx_q),
						aging_done: 1'b0};
				else if (!have_free_q)
					res_q <= '{status: ST_FULL, slot_index: '0, aging_done: 1'b1};
				else
					res_q <= '{status: ST_INSERTED, slot_index: SLOT_W'(free_idx_q),
						aging_done: ins_age};
			end

			if (do_ins) begin
				free_q[free_idx_q] <= 1'b0;
				ins_cnt_q          <= ins_next;
			end
			if (age_free) free_q[addr_s1] <= 1'b1;
			if (cmd.age_end) ins_cnt_q <= '0;

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				out_q       <= res_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.bypass   = bypass_q;
	assign sts.idx_last = (idx_q == ADDR_W'(NUM_ENTRIES - 1));
	assign sts.need_age = !found_q && (!have_free_q || ins_age);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_hit_used: assert property (@(posedge clk) disable iff (!arst_n)
		do_hit |-> !free_q[found_idx_q])
		else $error("hit on a free slot");

	a_ins_free: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |-> free_q[free_idx_q])
		else $error("insert into a used slot");

	a_age_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.age_end |=> ins_cnt_q == '0)
		else $error("insert count not cleared by aging");

endmodule

/* sv/dedup_cache_with_hit_aging.sv */
// The next item is accepted only after the result of the last one has been emitted.
// An item that triggers aging also runs a counter sweep over the whole table.
// Empty or too-long keys skip the scan and give their result directly. One item at a time;
// the scan reads one table entry per cycle from the key and counter memories.
// Reset: all slots free, insert count zero, registers at 8 and 25; no clearing pass.
// ----------------------------------------------------------------------------
// dedup_cache_with_hit_aging: key dedup cache with LFU hit counters
// Looks up, inserts and ages short keys; reports slot and status per item.
// ----------------------------------------------------------------------------
module dedup_cache_with_hit_aging (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  dca_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output dca_pkg::out_item_t             out_item,
	input  logic                           cfg_we,
	input  logic [dca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dca_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dca_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dca_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
